// ----- src/spfq_pkg.sv -----
// ----------------------------------------------------------------------------
// spfq_pkg
// Shared sizes, codes and types of the strict priority FIFO queue.
// ----------------------------------------------------------------------------
package spfq_pkg;

   localparam int LEVELS  = 3;
   localparam int DEPTH   = 16;
   localparam int ENTRIES = LEVELS * DEPTH;

   localparam int SYM_W  = 8;
   localparam int PRI_W  = 2;
   localparam int STAT_W = 2;
   localparam int LIDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int K_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ADDR_W = $clog2(ENTRIES);

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LIST   = 1'b1;

   typedef enum logic [STAT_W-1:0] {
      STAT_ACCEPTED = 2'd0,
      STAT_DROPPED  = 2'd1,
      STAT_LISTED   = 2'd2,
      STAT_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } state_type;

   typedef logic [LEVELS-1:0][CNT_W-1:0] count_vec_type;

   typedef struct packed {
      logic              en;
      logic [LIDX_W-1:0] level;
      logic [SYM_W-1:0]  symbol;
   } ins_req_type;

   typedef struct packed {
      logic              en;
      logic [LIDX_W-1:0] level;
      logic [K_W-1:0]    k;
   } rd_req_type;

   typedef struct packed {
      logic              found;
      logic [LIDX_W-1:0] idx;
   } lvl_pick_type;

   // highest non-empty level strictly below limit
   function automatic lvl_pick_type find_level(input logic [LEVELS-1:0] mask,
                                               input logic [LIDX_W:0] limit);
      lvl_pick_type pick;
      pick.found = 1'b0;
      pick.idx   = '0;
      for (int i = 0; i < LEVELS; i++) begin
         if (mask[i] && ((LIDX_W+1)'(i) < limit)) begin
            pick.found = 1'b1;
            pick.idx   = LIDX_W'(i);
         end
      end
      return pick;
   endfunction

endpackage

// ----- src/spfq_if.sv -----
// ----------------------------------------------------------------------------
// spfq_req_if / spfq_rsp_if
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface spfq_req_if;
   logic                       valid;
   logic                       ready;
   logic                       func;
   logic [spfq_pkg::SYM_W-1:0] symbol;
   logic [spfq_pkg::PRI_W-1:0] priority_req;

   modport source (output valid, func, symbol, priority_req, input ready);
   modport sink   (input valid, func, symbol, priority_req, output ready);
endinterface

interface spfq_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [spfq_pkg::STAT_W-1:0] status;
   logic [spfq_pkg::SYM_W-1:0]  item_symbol;
   logic [spfq_pkg::PRI_W-1:0]  item_priority;
   logic                        last;

   modport source (output valid, status, item_symbol, item_priority, last, input ready);
   modport sink   (input valid, status, item_symbol, item_priority, last, output ready);
endinterface

// ----- src/spfq_store.sv -----
// ----------------------------------------------------------------------------
// spfq_store
// Entry memory of all levels plus the per-level fill counters.
// ----------------------------------------------------------------------------
module spfq_store (
   input  logic                    clock,
   input  logic                    reset,
   input  spfq_pkg::ins_req_type   ins,
   input  spfq_pkg::rd_req_type    rd,
   output logic [spfq_pkg::SYM_W-1:0] rd_data,
   output spfq_pkg::count_vec_type counts
);
   import spfq_pkg::*;

   logic [SYM_W-1:0]  mem [ENTRIES];
   logic [SYM_W-1:0]  rd_data_ff;
   count_vec_type     level_count_ff;
   count_vec_type     level_count_in;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   assign wr_addr = ADDR_W'(ins.level) * ADDR_W'(DEPTH)
                  + ADDR_W'(level_count_ff[ins.level]);
   assign rd_addr = ADDR_W'(rd.level) * ADDR_W'(DEPTH) + ADDR_W'(rd.k);

   always_comb begin
      level_count_in = level_count_ff;
      if (ins.en) begin
         level_count_in[ins.level] = level_count_ff[ins.level] + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_count_ff <= '0;
      end else begin
         level_count_ff <= level_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ins.en) begin
         mem[wr_addr] <= ins.symbol;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign counts  = level_count_ff;

endmodule

// ----- src/strict_priority_fifo_queue.sv -----
// ----------------------------------------------------------------------------
// strict_priority_fifo_queue
// Strict priority store with one FIFO of byte symbols per level.
//
// req_bus carries request beats: func insert appends symbol to the FIFO of
// level priority_req (1 to LEVELS) and answers accepted, or dropped when the
// level is full or out of range. func list emits every stored symbol, top
// level first and each level oldest first, without removing any; last marks
// the final beat, and an empty store answers one store-empty beat.
// rsp_bus carries response beats from an output register, so a new request
// is taken in the same cycle as a waiting response beat leaves.
// Insert: the response beat is loaded into the output register in the cycle
// after the request, one insert per cycle while rsp_bus keeps up. List: the
// walk alternates a read state and a load state, set by the single read port
// of the entry memory (read of the entry, then load of the output register);
// request intake stops until the last beat of the list is loaded.
// Reset empties every level; no clearing pass is needed.
// A stall on rsp_bus holds the output register and in turn stops intake.
// ----------------------------------------------------------------------------
module strict_priority_fifo_queue (
   input  logic       clock,
   input  logic       reset,
   spfq_req_if.sink   req_bus,
   spfq_rsp_if.source rsp_bus
);
   import spfq_pkg::*;

   state_type         state_ff;
   state_type         state_in;
   logic [LIDX_W-1:0] cur_lvl_ff;
   logic [LIDX_W-1:0] cur_lvl_in;
   logic [K_W-1:0]    cur_k_ff;
   logic [K_W-1:0]    cur_k_in;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   status_type        rsp_status_ff;
   status_type        rsp_status_in;
   logic [SYM_W-1:0]  rsp_symbol_ff;
   logic [SYM_W-1:0]  rsp_symbol_in;
   logic [PRI_W-1:0]  rsp_priority_ff;
   logic [PRI_W-1:0]  rsp_priority_in;
   logic              rsp_last_ff;
   logic              rsp_last_in;

   logic              rsp_free;
   logic              accept;
   logic              out_load;
   logic              walk_last;
   logic              lvl_ok;
   logic              lvl_full;
   logic [LIDX_W-1:0] ins_idx;
   logic [LEVELS-1:0] nonempty;
   lvl_pick_type      top_pick;
   lvl_pick_type      below_pick;
   logic [CNT_W-1:0]  k_next;

   ins_req_type       ins;
   rd_req_type        rd;
   logic [SYM_W-1:0]  rd_data;
   count_vec_type     counts;

   spfq_store u_store (
      .clock   (clock),
      .reset   (reset),
      .ins     (ins),
      .rd      (rd),
      .rd_data (rd_data),
      .counts  (counts)
   );

   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && rsp_free;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      for (int i = 0; i < LEVELS; i++) begin
         nonempty[i] = (counts[i] != '0);
      end
   end

   assign top_pick   = find_level(nonempty, (LIDX_W+1)'(LEVELS));
   assign below_pick = find_level(nonempty, {1'b0, cur_lvl_ff});
   assign k_next     = CNT_W'(cur_k_ff) + CNT_W'(1);
   assign walk_last  = !(k_next < counts[cur_lvl_ff]) && !below_pick.found;

   assign lvl_ok   = (req_bus.priority_req != '0) && (int'(req_bus.priority_req) <= LEVELS);
   assign ins_idx  = LIDX_W'(req_bus.priority_req - PRI_W'(1));
   assign lvl_full = (counts[ins_idx] >= CNT_W'(DEPTH));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_bus.func == FUNC_LIST) && top_pick.found) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (rsp_free) begin
               state_in = walk_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs, memory requests and list cursor
   always_comb begin
      out_load        = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_symbol_in   = rsp_symbol_ff;
      rsp_priority_in = rsp_priority_ff;
      rsp_last_in     = rsp_last_ff;
      ins             = '0;
      rd              = '0;
      cur_lvl_in      = cur_lvl_ff;
      cur_k_in        = cur_k_ff;
      ins.level       = ins_idx;
      ins.symbol      = req_bus.symbol;
      rd.level        = cur_lvl_ff;
      rd.k            = cur_k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_symbol_in   = '0;
               rsp_priority_in = '0;
               rsp_last_in     = 1'b1;
               if (req_bus.func == FUNC_INSERT) begin
                  out_load = 1'b1;
                  if (lvl_ok && !lvl_full) begin
                     ins.en        = 1'b1;
                     rsp_status_in = STAT_ACCEPTED;
                  end else begin
                     rsp_status_in = STAT_DROPPED;
                  end
               end else if (!top_pick.found) begin
                  out_load      = 1'b1;
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  cur_lvl_in = top_pick.idx;
                  cur_k_in   = '0;
               end
            end
         end
         ST_READ: begin
            rd.en = 1'b1;
         end
         ST_LOAD: begin
            if (rsp_free) begin
               out_load        = 1'b1;
               rsp_status_in   = STAT_LISTED;
               rsp_symbol_in   = rd_data;
               rsp_priority_in = PRI_W'({1'b0, cur_lvl_ff} + (LIDX_W+1)'(1));
               rsp_last_in     = walk_last;
               if (k_next < counts[cur_lvl_ff]) begin
                  cur_k_in = K_W'(k_next);
               end else begin
                  cur_lvl_in = below_pick.idx;
                  cur_k_in   = '0;
               end
            end
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_lvl_ff      <= cur_lvl_in;
      cur_k_ff        <= cur_k_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_symbol_ff   <= rsp_symbol_in;
      rsp_priority_ff <= rsp_priority_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.item_symbol   = rsp_symbol_ff;
   assign rsp_bus.item_priority = rsp_priority_ff;
   assign rsp_bus.last          = rsp_last_ff;

endmodule

// ----- tb/strict_priority_fifo_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_fifo_queue_tb
// Drives insert and list requests into the priority store under varying
// request gaps and response stalls. A scoreboard keeps its own copy of every
// level's FIFO and checks each response beat, field by field, in order.
// ----------------------------------------------------------------------------
module strict_priority_fifo_queue_tb;
   import spfq_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 20;
   localparam int LIST_PCT      = 12;

   class priority_store_scoreboard;
      typedef struct packed {
         logic [STAT_W-1:0] status;
         logic [SYM_W-1:0]  symbol;
         logic [PRI_W-1:0]  level;
         logic              last;
      } beat_type;

      logic [SYM_W-1:0] level_fifo[LEVELS][$];
      beat_type         expected_beats[$];
      int               mismatches;

      function void add_beat(status_type st, logic [SYM_W-1:0] sym,
                             logic [PRI_W-1:0] lvl, logic last);
         beat_type b;
         b.status = st;
         b.symbol = sym;
         b.level  = lvl;
         b.last   = last;
         expected_beats.push_back(b);
      endfunction

      function int pending();
         return expected_beats.size();
      endfunction

      function void note_request(logic func, logic [SYM_W-1:0] sym,
                                 logic [PRI_W-1:0] pri);
         int lvl;
         int n;
         lvl = int'(pri);
         n   = 0;
         if (func == FUNC_INSERT) begin
            if (lvl < 1 || lvl > LEVELS || level_fifo[lvl-1].size() >= DEPTH) begin
               add_beat(STAT_DROPPED, '0, '0, 1'b1);
            end else begin
               level_fifo[lvl-1].push_back(sym);
               add_beat(STAT_ACCEPTED, '0, '0, 1'b1);
            end
         end else begin
            for (int l = LEVELS; l >= 1; l--) begin
               for (int k = 0; k < level_fifo[l-1].size(); k++) begin
                  add_beat(STAT_LISTED, level_fifo[l-1][k], PRI_W'(l), 1'b0);
                  n++;
               end
            end
            if (n == 0)
               add_beat(STAT_EMPTY, '0, '0, 1'b1);
            else
               expected_beats[expected_beats.size()-1].last = 1'b1;
         end
      endfunction

      function void check_response(logic [STAT_W-1:0] st, logic [SYM_W-1:0] sym,
                                   logic [PRI_W-1:0] lvl, logic last);
         beat_type b;
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: status %0d symbol %02h level %0d last %0d",
                        st, sym, lvl, last);
         end else begin
            b = expected_beats.pop_front();
            if (b.status !== st || b.symbol !== sym || b.level !== lvl ||
                b.last !== last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"beat mismatch: status exp %0d got %0d, symbol exp %02h got %02h,",
                            " level exp %0d got %0d, last exp %0d got %0d"},
                           b.status, st, b.symbol, sym, b.level, lvl, b.last, last);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   idle_pct;
   int   stall_pct;

   priority_store_scoreboard beat_board;

   spfq_req_if req_bus();
   spfq_rsp_if rsp_bus();

   strict_priority_fifo_queue u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // response side stalls at the rate of the current phase
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         beat_board.check_response(rsp_bus.status, rsp_bus.item_symbol,
                                   rsp_bus.item_priority, rsp_bus.last);
   end

   task automatic send_request(input logic func, input logic [SYM_W-1:0] sym,
                               input logic [PRI_W-1:0] pri);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.func         <= func;
      req_bus.symbol       <= sym;
      req_bus.priority_req <= pri;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      beat_board.note_request(func, sym, pri);
   endtask

   task automatic run_random_phase(input int count, input int idle, input int stall);
      idle_pct  = idle;
      stall_pct = stall;
      repeat (count) begin
         send_request(($urandom_range(99) < LIST_PCT) ? FUNC_LIST : FUNC_INSERT,
                      SYM_W'($urandom_range(255)),
                      ($urandom_range(9) == 0) ? 2'd0 : PRI_W'($urandom_range(1, LEVELS)));
      end
   endtask

   initial begin
      beat_board = new();
      idle_pct   = 0;
      stall_pct  = 0;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.func         <= FUNC_INSERT;
      req_bus.symbol       <= '0;
      req_bus.priority_req <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // list on empty store
      send_request(FUNC_LIST, 8'h00, 2'd0);
      send_request(FUNC_INSERT, 8'h00, 2'd1);
      send_request(FUNC_INSERT, 8'hFF, 2'd3);
      send_request(FUNC_INSERT, 8'hA5, 2'd2);
      send_request(FUNC_INSERT, 8'h5A, 2'd1);
      // level zero is out of range
      send_request(FUNC_INSERT, 8'hFF, 2'd0);
      send_request(FUNC_LIST, 8'hFF, 2'd3);
      // fill the top level, then overflow it
      for (int i = 0; i < DEPTH - 1; i++)
         send_request(FUNC_INSERT, SYM_W'(i * 17), 2'd3);
      send_request(FUNC_INSERT, 8'h3C, 2'd3);
      send_request(FUNC_LIST, 8'h00, 2'd1);

      run_random_phase(82, 0, 0);
      run_random_phase(83, 59, 0);

      // drain everything before resuming
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (beat_board.pending() != 0);

      run_random_phase(83, 0, 59);
      run_random_phase(82, 13, 13);

      req_bus.valid <= 1'b0;
      do @(posedge clock); while (beat_board.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (beat_board.mismatches == 0 && beat_board.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
